// ===== hdl/cms_pkg.sv =====
package cms_pkg;

  // default geometry of the sketch
  localparam int ROWS_DEF       = 3;
  localparam int INDEX_BITS_DEF = 21;

  // fixed field widths
  localparam int HASH_W = 64;
  localparam int CNT_W  = 8;
  localparam int OUT_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

// ===== hdl/cms_ram.sv =====
module cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read every cycle, the old word during a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/count_min_sketch_counter_core.sv =====
// count-min sketch counter: 8-bit saturating counters, one RAM of 2^INDEX_BITS per row
// each word's row cells are read as it is accepted and written back in the update state,
// which also registers the result; no word is taken meanwhile or while a result stalls
// reset: threshold goes to 0, then a clearing pass zeroes every counter, one address
//   a cycle in all rows at once; no input
//   word is taken until it ends, configuration writes are taken throughout
module count_min_sketch_counter_core
  import cms_pkg::*;
#(
  parameter int ROWS       = ROWS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,       // count_threshold
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [HASH_W-1:0] in_tdata,       // kmer_hash [63:0]
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,      // estimated_count [7:0]
  output logic              out_tuser       // above_threshold [0]
);

  localparam int ROW_DEPTH = 1 << INDEX_BITS;

  state_t state_r, state_nxt;

  logic [INDEX_BITS-1:0] clr_addr_r;
  logic [INDEX_BITS-1:0] clr_addr_nxt;
  logic [INDEX_BITS-1:0] addr_r     [ROWS];
  logic [INDEX_BITS-1:0] hash_slice [ROWS];
  logic [INDEX_BITS-1:0] ram_addr   [ROWS];
  logic [CNT_W-1:0]      ram_rdata  [ROWS];
  logic [CNT_W-1:0]      cnt_upd    [ROWS];
  logic [CNT_W-1:0]      ram_wdata;
  logic                  ram_we;
  logic                  upd_sel;

  logic [CNT_W-1:0] thr_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_flag_r;
  logic [CNT_W-1:0] est_min;
  logic             in_acc;

  assign in_acc = in_tvalid && in_tready;

  // hash slices, lowest slice is row 0
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    assign hash_slice[r] = in_tdata[r*INDEX_BITS +: INDEX_BITS];
    // saturating increment of the word read back
    assign cnt_upd[r] = (ram_rdata[r] == CNT_MAX) ? CNT_MAX : ram_rdata[r] + CNT_W'(1);

    cms_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ROW_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .addr  (ram_addr[r]),
      .wdata (upd_sel ? cnt_upd[r] : ram_wdata),
      .rdata (ram_rdata[r])
    );
  end

  // minimum over the updated counters
  always_comb begin
    est_min = CNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (cnt_upd[r] < est_min) begin
        est_min = cnt_upd[r];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + INDEX_BITS'(1);
        if (clr_addr_r == {INDEX_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // sequencer outputs and ram address select
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    upd_sel   = 1'b0;
    ram_wdata = '0;
    for (int r = 0; r < ROWS; r++) begin
      ram_addr[r] = hash_slice[r];
    end
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        for (int r = 0; r < ROWS; r++) begin
          ram_addr[r] = clr_addr_r;
        end
      end
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
      end
      ST_UPDATE: begin
        ram_we  = 1'b1;
        upd_sel = 1'b1;
        for (int r = 0; r < ROWS; r++) begin
          ram_addr[r] = addr_r[r];
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (state_r == ST_UPDATE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int r = 0; r < ROWS; r++) begin
        addr_r[r] <= hash_slice[r];
      end
    end
    if (state_r == ST_UPDATE) begin
      out_count_r <= est_min;
      out_flag_r  <= est_min > thr_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_flag_r;

  // no input word is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready)
    else $error("input accepted during clearing pass");

  // every accepted word is answered by a valid result word
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("result missing two cycles after accept");

  // an updated counter is never zero, so neither is the estimate
  a_nonzero_est: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != '0)
    else $error("zero estimate reported");

  // a stalled result does not block into a new accept
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result stalled");

endmodule

// ===== tb/cms_result_checker.sv =====
module cms_result_checker
  import cms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [HASH_W-1:0] in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic              out_tuser,
  output int                owed,
  output int                fail_count
);

  typedef struct packed {
    logic [OUT_W-1:0] estimate;
    logic             over;
  } sketch_result_t;

  // sparse copy of the counter rows, key is {row, slice}; missing cells read as zero
  logic [CNT_W-1:0] sketch_cells [bit [INDEX_BITS_DEF+1:0]];
  logic [CNT_W-1:0] threshold_copy;
  sketch_result_t   owed_results[$];

  initial begin
    owed       = 0;
    fail_count = 0;
  end

  // bump the addressed counter in every row, return the smallest updated one
  function automatic logic [CNT_W-1:0] bump_and_min(logic [HASH_W-1:0] hash);
    bit [INDEX_BITS_DEF+1:0] key;
    logic [CNT_W-1:0]        slot_cnt;
    logic [CNT_W-1:0]        lowest;
    lowest = CNT_MAX;
    for (int r = 0; r < ROWS_DEF; r++) begin
      key      = {2'(r), hash[INDEX_BITS_DEF-1:0]};
      slot_cnt = sketch_cells.exists(key) ? sketch_cells[key] : '0;
      if (slot_cnt != CNT_MAX) slot_cnt = slot_cnt + 1'b1;
      sketch_cells[key] = slot_cnt;
      if (slot_cnt < lowest) lowest = slot_cnt;
      hash = hash >> INDEX_BITS_DEF;
    end
    return lowest;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    sketch_result_t want;
    if (!rst_n) begin
      sketch_cells.delete();
      owed_results.delete();
      threshold_copy = '0;
    end else begin
      if (cfg_valid && cfg_ready) threshold_copy = cfg_data;

      // result words first, an input taken at this edge cannot answer yet
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $error("result word with nothing expected: estimated_count %0d above_threshold %0b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_tdata !== want.estimate) begin
            $error("estimated_count: expected %0d, actual %0d", want.estimate, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.over) begin
            $error("above_threshold: expected %0b, actual %0b", want.over, out_tuser);
            fail_count++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        want.estimate = bump_and_min(in_tdata);
        want.over     = want.estimate > threshold_copy;
        owed_results.push_back(want);
      end
    end
    owed = owed_results.size();
  end

endmodule

// ===== tb/tb_count_min_sketch_counter_core.sv =====
module tb_count_min_sketch_counter_core;
  import cms_pkg::*;

  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 300;
  localparam int HOT_HASHES = 4;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [HASH_W-1:0] in_tdata;    // kmer_hash [63:0]
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;   // estimated_count [7:0]
  logic              out_tuser;   // above_threshold [0]

  int owed;
  int fail_count;
  int idle_pct;

  logic [HASH_W-1:0] hot_pool [HOT_HASHES];

  count_min_sketch_counter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cms_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .owed       (owed),
    .fail_count (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop; the clearing pass alone visits every address of the row RAMs
  initial begin
    #80_000_000;
    $display("tb_count_min_sketch_counter_core: errors");
    $finish;
  end

  // result side back-pressure in random bursts, started with chance idle_pct percent
  initial begin : stall_gen
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // write the threshold register, block must be idle
  task automatic write_threshold(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one hash word, returns at the falling edge after it is taken
  task automatic send_hash(input logic [HASH_W-1:0] hash);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= hash;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // drop valid and let every owed result drain
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (owed == 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [HASH_W-1:0] random_hash();
    return {$urandom, $urandom};
  endfunction

  // mostly repeated hot hashes so counters climb and saturate, some
  // hashes sharing slices with hot ones, the rest fresh random
  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] slice_mask;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      hash = hot_pool[0];
    end else if (roll < 55) begin
      hash = hot_pool[$urandom_range(1, HOT_HASHES-1)];
    end else if (roll < 70) begin
      hash       = hot_pool[$urandom_range(0, HOT_HASHES-1)];
      slice_mask = ((64'd1 << INDEX_BITS_DEF) - 1) << (INDEX_BITS_DEF * $urandom_range(0, 2));
      hash       = (hash & ~slice_mask) | (random_hash() & slice_mask);
    end else begin
      hash = random_hash();
    end
    // top bit is outside every slice
    hash[HASH_W-1] = 1'($urandom_range(0, 1));
    return hash;
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] phase_threshold [PHASES];
    int               phase_idle      [PHASES];
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    idle_pct  = 0;

    phase_threshold = '{8'd255, 8'd0, 8'($urandom_range(2, 253)), 8'd1, 8'd254,
                        8'($urandom_range(2, 253))};
    phase_idle      = '{25, 40, 0, 25, 10, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at threshold zero
    write_threshold(8'd0);
    idle_pct = 20;
    send_hash(64'h0000_0000_0000_0000);
    send_hash(64'h0000_0000_0000_0000);
    send_hash(64'hFFFF_FFFF_FFFF_FFFF);
    send_hash(64'h7FFF_FFFF_FFFF_FFFF);   // same cells as all ones, top bit ignored
    send_hash(64'h8000_0000_0000_0000);   // same cells as zero
    send_hash(64'h0000_0000_0020_0000);   // shares row 0 and row 2 cells with zero
    send_hash(64'h0000_0000_001F_FFFF);
    send_hash(64'h0000_03FF_FFE0_0000);
    send_hash(64'h7FFF_FC00_0000_0000);
    send_hash(64'hAAAA_AAAA_AAAA_AAAA);
    send_hash(64'h5555_5555_5555_5555);
    send_hash(64'hAAAA_AAAA_AAAA_AAAA);
    send_hash(64'h0000_0000_001F_FFFF);
    send_hash(64'h0000_0000_0000_0001);
    send_hash(64'h0000_0400_0000_0000);
    send_hash(64'h0000_0000_0000_0000);
    drain_results();

    // random phases, each under its own threshold
    foreach (hot_pool[i]) hot_pool[i] = random_hash();
    // hot hashes 0 and 1 collide in row 1
    hot_pool[1][2*INDEX_BITS_DEF-1:INDEX_BITS_DEF] =
      hot_pool[0][2*INDEX_BITS_DEF-1:INDEX_BITS_DEF];
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_threshold[p]);
      idle_pct = phase_idle[p];
      repeat (PHASE_LEN) send_hash(pick_hash());
      drain_results();
    end

    if (fail_count == 0 && owed == 0) begin
      $display("tb_count_min_sketch_counter_core: clean");
    end else begin
      $display("tb_count_min_sketch_counter_core: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cms_pkg.sv
hdl/cms_ram.sv
hdl/count_min_sketch_counter_core.sv
tb/cms_result_checker.sv
tb/tb_count_min_sketch_counter_core.sv
